// File: design/tiw_pkg.sv
// ----------------------------------------------------------------------------
// tiw_pkg
// shared types and fixed field widths of the trie insert and walk engine
// ----------------------------------------------------------------------------
package tiw_pkg;

  // fixed widths of the transaction fields
  localparam int SYMBOL_W     = 8;
  localparam int NODE_INDEX_W = 10;
  localparam int NODES_USED_W = 11;
  localparam int STATUS_W     = 3;

  // symbol_base after reset
  localparam logic [SYMBOL_W-1:0] SYMBOL_BASE_RST = 8'd97;

  // mode codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FIND   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING = 3'd0,
    ST_CREATED  = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

endpackage

// File: design/tiw_child_mem.sv
// ----------------------------------------------------------------------------
// tiw_child_mem
// child table: single synchronous ram with a registered read and a
// clearing sweep after reset that zeroes every entry, one per cycle
// ----------------------------------------------------------------------------
module tiw_child_mem #(
  parameter int DEPTH  = 32768,
  parameter int DATA_W = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic                     clr_busy
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;
  logic              clr_busy_r;
  logic              clr_busy_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // write port, shared by the sweep and the engine
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: design/trie_insert_and_walk.sv
// ----------------------------------------------------------------------------
// trie_insert_and_walk
// array-based trie engine: walks, inserts and finds words one symbol per
// transaction through a child table held in one synchronous ram
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | start && !busy         | in_mode, in_symbol, in_word_end
//  result   | out_valid (one cycle)  | out_node_index, out_status,
//           |                        | out_nodes_used, out_last_of_word
//  config   | cfg_we                 | cfg_data (symbol_base)
//
//  - the accept cycle issues the child table read, the next cycle decides and
//    writes back a new child; busy is high during that decision cycle, so the
//    next symbol sees the updated current node
//  - the result strobe rises the cycle after the decision cycle
//  - after reset a clearing sweep zeroes the child table, one entry a cycle,
//    all MAX_NODES*ALPHABET entries (32768 at the defaults); busy is high
//    meanwhile and until S_CLEAR sees it end, config writes are still taken
//  - the receiver cannot stall; every result is shown for exactly one cycle
//
module trie_insert_and_walk
  import tiw_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input transaction
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [SYMBOL_W-1:0]     in_symbol,
  input  logic                    in_word_end,
  // result transaction
  output logic                    out_valid,
  output logic [NODE_INDEX_W-1:0] out_node_index,
  output logic [STATUS_W-1:0]     out_status,
  output logic [NODES_USED_W-1:0] out_nodes_used,
  output logic                    out_last_of_word,
  // configuration
  input  logic                    cfg_we,
  input  logic [SYMBOL_W-1:0]     cfg_data
);

  // derived sizes
  localparam int DEPTH  = MAX_NODES * ALPHABET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SLOT_W = $clog2(ALPHABET);
  localparam int DIFF_W = SYMBOL_W + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SYMBOL_W-1:0]     sym_base_r, sym_base_nxt;
  logic [NODE_W-1:0]       cur_node_r, cur_node_nxt;
  logic                    lost_r, lost_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  // transaction held between the read and the decision
  logic                    p_mode_r, p_mode_nxt;
  logic                    p_word_end_r, p_word_end_nxt;
  logic                    p_bad_r, p_bad_nxt;
  logic [ADDR_W-1:0]       p_addr_r, p_addr_nxt;
  // registered result
  logic                    out_valid_r, out_valid_nxt;
  logic [NODE_INDEX_W-1:0] out_node_r, out_node_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [NODES_USED_W-1:0] out_used_r, out_used_nxt;
  logic                    out_last_r, out_last_nxt;

  // child table ports
  logic                    mem_rd_en;
  logic [ADDR_W-1:0]       mem_addr;
  logic [NODE_W-1:0]       mem_rd_data;
  logic                    mem_wr_en;
  logic                    clr_busy;

  // symbol decode
  logic [DIFF_W-1:0]       sym_diff;
  logic                    sym_bad;
  logic [SLOT_W-1:0]       sym_slot;
  logic                    accept;

  status_t                 status_w;
  logic [NODE_W-1:0]       node_w;

  // slot = symbol - base; a borrow or a slot past the alphabet is a bad symbol
  assign sym_diff = {1'b0, in_symbol} - {1'b0, sym_base_r};
  assign sym_bad  = sym_diff[DIFF_W-1] || (sym_diff >= DIFF_W'(ALPHABET));
  assign sym_slot = sym_diff[SLOT_W-1:0];

  assign accept   = start && (state_r == S_IDLE);

  // child entry address of the current node; only read on a live walk
  assign mem_addr  = ADDR_W'(cur_node_r) * ADDR_W'(ALPHABET) + ADDR_W'(sym_slot);
  assign mem_rd_en = accept && !sym_bad && !lost_r;

  always_comb begin
    state_nxt      = state_r;
    sym_base_nxt   = sym_base_r;
    cur_node_nxt   = cur_node_r;
    lost_nxt       = lost_r;
    count_nxt      = count_r;
    p_mode_nxt     = p_mode_r;
    p_word_end_nxt = p_word_end_r;
    p_bad_nxt      = p_bad_r;
    p_addr_nxt     = p_addr_r;
    out_valid_nxt  = 1'b0;
    out_node_nxt   = out_node_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    out_last_nxt   = out_last_r;
    mem_wr_en      = 1'b0;
    status_w       = ST_ABSENT;
    node_w         = '0;

    // config is taken in any state
    if (cfg_we) begin
      sym_base_nxt = cfg_data;
    end

    case (state_r)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          p_mode_nxt     = in_mode;
          p_word_end_nxt = in_word_end;
          p_bad_nxt      = sym_bad;
          p_addr_nxt     = mem_addr;
          state_nxt      = S_LOOK;
        end
      end

      S_LOOK: begin
        // decision order: bad symbol, lost walk, existing child, find miss,
        // full table, new child
        if (p_bad_r) begin
          status_w = ST_BAD;
          lost_nxt = 1'b1;
        end else if (lost_r) begin
          status_w = ST_ABSENT;
        end else if (mem_rd_data != '0) begin
          status_w     = ST_EXISTING;
          node_w       = mem_rd_data;
          cur_node_nxt = mem_rd_data;
        end else if (p_mode_r == MODE_FIND) begin
          status_w = ST_ABSENT;
          lost_nxt = 1'b1;
        end else if (count_r == CNT_W'(MAX_NODES)) begin
          status_w = ST_FULL;
          lost_nxt = 1'b1;
        end else begin
          // allocate the next free node and link it under the current one
          status_w     = ST_CREATED;
          node_w       = count_r[NODE_W-1:0];
          cur_node_nxt = count_r[NODE_W-1:0];
          count_nxt    = count_r + CNT_W'(1);
          mem_wr_en    = 1'b1;
        end

        // word end returns the walk to the root whatever the status
        if (p_word_end_r) begin
          cur_node_nxt = '0;
          lost_nxt     = 1'b0;
        end

        out_valid_nxt  = 1'b1;
        out_node_nxt   = NODE_INDEX_W'(node_w);
        out_status_nxt = status_w;
        out_used_nxt   = NODES_USED_W'(count_nxt);
        out_last_nxt   = p_word_end_r;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sym_base_r  <= SYMBOL_BASE_RST;
      cur_node_r  <= '0;
      lost_r      <= 1'b0;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sym_base_r  <= sym_base_nxt;
      cur_node_r  <= cur_node_nxt;
      lost_r      <= lost_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    p_mode_r     <= p_mode_nxt;
    p_word_end_r <= p_word_end_nxt;
    p_bad_r      <= p_bad_nxt;
    p_addr_r     <= p_addr_nxt;
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
    out_last_r   <= out_last_nxt;
  end

  // the write lands at the end of the decision cycle, the next read is issued
  // in the idle cycle after it at the earliest, so no forwarding path is needed
  tiw_child_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (NODE_W)
  ) u_child_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_addr),
    .rd_data  (mem_rd_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (p_addr_r),
    .wr_data  (count_r[NODE_W-1:0]),
    .clr_busy (clr_busy)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_node_index   = out_node_r;
  assign out_status       = out_status_r;
  assign out_nodes_used   = out_used_r;
  assign out_last_of_word = out_last_r;

  // a result only follows a decision cycle
  a_result_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_LOOK))
    else $error("result strobe without a decision cycle");

  // the allocation count stays within the root and the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(MAX_NODES)))
    else $error("node count out of range");

  // a created child bumps the count by exactly one
  a_created_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_CREATED) |-> count_r == $past(count_r) + CNT_W'(1))
    else $error("created child without a count step");

  // table writes only come from a decision cycle after the sweep
  a_write_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_LOOK && !clr_busy))
    else $error("child table write outside a decision cycle");

  // failed symbols report the root index
  a_fail_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_ABSENT || out_status_r == ST_FULL ||
                     out_status_r == ST_BAD)) |-> out_node_r == '0)
    else $error("failed symbol with a nonzero node index");

endmodule

// File: test/trie_insert_and_walk_tb.sv
// ----------------------------------------------------------------------------
// trie_insert_and_walk_tb
// self-checking bench for the trie engine: words are inserted and looked up
// one symbol a transaction under several symbol bases, and every result is
// compared with a trie kept inside the bench, through to a full node table
// ----------------------------------------------------------------------------
module trie_insert_and_walk_tb;
  import tiw_pkg::*;

  localparam int MAX_NODES   = 1024;
  localparam int ALPHABET    = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int WORD_MAX    = 8;
  localparam int BOOK_DEPTH  = 32;
  localparam int MAX_REPORTS = 10;

  // one symbol transaction as driven on the input ports
  typedef struct packed {
    logic                mode;
    logic [SYMBOL_W-1:0] symbol;
    logic                word_end;
  } sym_txn_t;

  // one result transaction
  typedef struct packed {
    logic [NODE_INDEX_W-1:0] node_index;
    status_t                 status;
    logic [NODES_USED_W-1:0] nodes_used;
    logic                    last_of_word;
  } walk_result_t;

  // a word kept so that it can be looked up again later
  typedef struct packed {
    logic [3:0]                         len;
    logic [WORD_MAX-1:0][SYMBOL_W-1:0] syms;
  } word_rec_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_mode = MODE_INSERT;
  logic [SYMBOL_W-1:0]     in_symbol = '0;
  logic                    in_word_end = 1'b0;
  logic                    out_valid;
  logic [NODE_INDEX_W-1:0] out_node_index;
  logic [STATUS_W-1:0]     out_status;
  logic [NODES_USED_W-1:0] out_nodes_used;
  logic                    out_last_of_word;
  logic                    cfg_we = 1'b0;
  logic [SYMBOL_W-1:0]     cfg_data = '0;

  trie_insert_and_walk #(
    .MAX_NODES (MAX_NODES),
    .ALPHABET  (ALPHABET)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_symbol        (in_symbol),
    .in_word_end      (in_word_end),
    .out_valid        (out_valid),
    .out_node_index   (out_node_index),
    .out_status       (out_status),
    .out_nodes_used   (out_nodes_used),
    .out_last_of_word (out_last_of_word),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // symbols waiting to be driven, and results owed by the engine in order
  sym_txn_t     symbol_q[$];
  walk_result_t result_q[$];
  word_rec_t    word_book[$];
  int unsigned  queued = 0;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // trie kept by the bench; an entry of zero is an absent child since the root
  // is never anybody's child
  // ---------------------------------------------------------------------------
  bit [NODE_INDEX_W-1:0] child_tbl [MAX_NODES*ALPHABET];
  int unsigned           node_total = 1;
  int unsigned           cur_node = 0;
  bit                    walk_lost = 1'b0;
  logic [SYMBOL_W-1:0]   sym_base = SYMBOL_BASE_RST;

  // advances the walk by one symbol and returns the result it must produce
  function automatic walk_result_t walk_symbol(input logic mode,
                                               input logic [SYMBOL_W-1:0] sym,
                                               input logic eow);
    walk_result_t r;
    int unsigned  slot;
    int unsigned  idx;
    int unsigned  child;
    r.node_index   = '0;
    r.last_of_word = eow;
    // symbol range check wins over everything, even a lost walk
    if (sym < sym_base || (sym - sym_base) >= ALPHABET) begin
      r.status  = ST_BAD;
      walk_lost = 1'b1;
    end else if (walk_lost) begin
      r.status = ST_ABSENT;
    end else begin
      slot  = sym - sym_base;
      idx   = cur_node * ALPHABET + slot;
      child = 32'(child_tbl[idx]);
      if (child != 0) begin
        r.status     = ST_EXISTING;
        r.node_index = NODE_INDEX_W'(child);
        cur_node     = child;
      end else if (mode == MODE_FIND) begin
        r.status  = ST_ABSENT;
        walk_lost = 1'b1;
      end else if (node_total >= MAX_NODES) begin
        r.status  = ST_FULL;
        walk_lost = 1'b1;
      end else begin
        child_tbl[idx] = NODE_INDEX_W'(node_total);
        r.status       = ST_CREATED;
        r.node_index   = NODE_INDEX_W'(node_total);
        cur_node       = node_total;
        node_total++;
      end
    end
    r.nodes_used = NODES_USED_W'(node_total);
    // end mark always sends the walk home, lost or not
    if (eow) begin
      cur_node  = 0;
      walk_lost = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of back-to-back transactions separated by random gaps; a
  // raised start holds its symbol until the engine takes it
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    sym_txn_t txn;
    logic     taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      // the ports still hold the symbol that was just accepted
      if (taken)
        result_q.insert(result_q.size(), walk_symbol(in_mode, in_symbol, in_word_end));
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (symbol_q.size() > 0) begin
          txn = symbol_q.pop_front();
          in_mode     <= txn.mode;
          in_symbol   <= txn.symbol;
          in_word_end <= txn.word_end;
          start       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed result must match the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t got;
    if (rst_n && out_valid) begin
      got = '{out_node_index, status_t'(out_status), out_nodes_used, out_last_of_word};
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: node=%0d status=%0d used=%0d last=%0b",
                   out_node_index, out_status, out_nodes_used, out_last_of_word);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected node=%0d status=%0d used=%0d last=%0b,",
                      " got node=%0d status=%0d used=%0d last=%0b"},
                     want.node_index, want.status, want.nodes_used, want.last_of_word,
                     out_node_index, out_status, out_nodes_used, out_last_of_word);
        end
      end
    end
  end

  // run limit; it also covers the clearing sweep after reset
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** trie_insert_and_walk: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_sym(input logic mode, input logic [SYMBOL_W-1:0] sym,
                           input logic eow);
    sym_txn_t t;
    t = '{mode, sym, eow};
    symbol_q.insert(symbol_q.size(), t);
    queued++;
  endtask

  // highest slot that still fits in eight bits under the current base
  function automatic int unsigned top_slot();
    int unsigned room;
    room = 255 - sym_base;
    return (room < ALPHABET - 1) ? room : ALPHABET - 1;
  endfunction

  function automatic logic [SYMBOL_W-1:0] bad_symbol();
    int unsigned s;
    do
      s = $urandom_range(0, 255);
    while (s >= sym_base && s - sym_base < ALPHABET);
    return SYMBOL_W'(s);
  endfunction

  // narrow words share prefixes, so later words walk existing children
  function automatic word_rec_t make_word(input bit narrow);
    word_rec_t   w;
    int unsigned hi;
    hi = top_slot();
    if (narrow && hi > 3)
      hi = 3;
    w.syms = '0;
    w.len  = 4'($urandom_range(1, WORD_MAX));
    for (int i = 0; i < w.len; i++)
      w.syms[i] = SYMBOL_W'(sym_base + $urandom_range(0, hi));
    return w;
  endfunction

  task automatic queue_word(input word_rec_t w, input logic mode);
    for (int i = 0; i < w.len; i++)
      queue_sym(mode, w.syms[i], i == w.len - 1);
  endtask

  // mostly well-formed insert and find words, plus broken words and noise
  task automatic queue_traffic(input int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    int unsigned cut;
    word_rec_t   w;
    goal = queued + n_items;
    while (queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        w = make_word(1'($urandom_range(0, 1)));
        queue_word(w, MODE_INSERT);
        word_book.insert(word_book.size(), w);
        if (word_book.size() > BOOK_DEPTH)
          void'(word_book.pop_front());
      end else if (pick < 65 && word_book.size() > 0) begin
        // look up a known word or one of its prefixes
        w = word_book[$urandom_range(0, word_book.size() - 1)];
        if ($urandom_range(0, 1))
          w.len = 4'($urandom_range(1, w.len));
        queue_word(w, MODE_FIND);
      end else if (pick < 75) begin
        queue_word(make_word(1'($urandom_range(0, 1))), MODE_FIND);
      end else if (pick < 84) begin
        // each symbol with its own mode
        w = make_word(1'b1);
        for (int i = 0; i < w.len; i++)
          queue_sym(1'($urandom_range(0, 1)), w.syms[i], i == w.len - 1);
      end else if (pick < 92) begin
        // out-of-range symbol somewhere inside an otherwise good word
        w = make_word(1'($urandom_range(0, 1)));
        cut = $urandom_range(0, w.len - 1);
        w.syms[cut] = bad_symbol();
        queue_word(w, 1'($urandom_range(0, 1)));
      end else begin
        queue_sym(1'($urandom_range(0, 1)), SYMBOL_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // all symbols accepted and all results back
  task automatic wait_idle();
    do
      @(posedge clk);
    while (symbol_q.size() != 0 || start || result_q.size() != 0);
  endtask

  task automatic write_symbol_base(input logic [SYMBOL_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    sym_base = value;
    // remembered words mean little under a new base
    word_book.delete();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    word_rec_t w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // written while the clearing sweep is still running
    write_symbol_base(8'd97);

    // directed: 97 is 'a'
    queue_sym(MODE_FIND, 8'd97, 1'b1);      // empty trie, find misses
    queue_sym(MODE_INSERT, 8'd97, 1'b1);    // first node created
    queue_sym(MODE_INSERT, 8'd97, 1'b0);    // walk existing child
    queue_sym(MODE_INSERT, 8'd98, 1'b1);    // then grow below it
    queue_sym(MODE_FIND, 8'd97, 1'b0);
    queue_sym(MODE_FIND, 8'd98, 1'b1);      // full hit
    queue_sym(MODE_FIND, 8'd97, 1'b0);
    queue_sym(MODE_FIND, 8'd122, 1'b0);     // miss in the middle of a word
    queue_sym(MODE_FIND, 8'd97, 1'b1);      // stays lost until the end mark
    queue_sym(MODE_INSERT, 8'd96, 1'b0);    // just below the base
    queue_sym(MODE_INSERT, 8'd97, 1'b1);    // lost after a bad symbol
    queue_sym(MODE_INSERT, 8'd128, 1'b1);   // highest slot
    queue_sym(MODE_FIND, 8'd128, 1'b1);
    queue_sym(MODE_INSERT, 8'd129, 1'b1);   // one past the highest slot
    queue_sym(MODE_INSERT, 8'd0, 1'b1);
    queue_sym(MODE_FIND, 8'd255, 1'b1);
    queue_sym(MODE_FIND, 8'd97, 1'b0);      // modes mixed within one word
    queue_sym(MODE_INSERT, 8'd99, 1'b0);
    queue_sym(MODE_FIND, 8'd99, 1'b1);
    queue_sym(MODE_INSERT, 8'd97, 1'b0);
    queue_sym(MODE_INSERT, 8'd99, 1'b1);
    queue_sym(MODE_FIND, 8'd200, 1'b1);     // bad symbol carrying the end mark
    queue_sym(MODE_FIND, 8'd97, 1'b1);      // back at the root afterwards
    queue_traffic(600);
    wait_idle();

    // lowest base: slots are symbols 0..31
    write_symbol_base(8'd0);
    queue_traffic(300);
    wait_idle();

    // highest base: only 255 is a legal symbol
    write_symbol_base(8'd255);
    queue_traffic(80);
    wait_idle();

    // base whose top slot is symbol 255
    write_symbol_base(8'd224);
    queue_traffic(120);
    wait_idle();

    // fill the node table with random inserts over the whole alphabet
    write_symbol_base(SYMBOL_W'($urandom_range(1, 223)));
    while (node_total < MAX_NODES) begin
      w = make_word(1'b0);
      queue_word(w, MODE_INSERT);
      while (symbol_q.size() != 0)
        @(posedge clk);
    end

    // full table: new children are refused, existing paths still walk
    queue_traffic(250);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("** trie_insert_and_walk: PASSED **");
    else
      $display("** trie_insert_and_walk: FAILED **");
    $finish;
  end

endmodule
